// ===== rtl/lkvc_pkg.sv =====
`default_nettype none
package lkvc_pkg;

  localparam int CAP_W   = 5;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;

  localparam logic [CAP_W-1:0]          CAP_RESET  = 5'd16;
  localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

  localparam logic REQ_GET = 1'b0;
  localparam logic REQ_PUT = 1'b1;

  typedef struct packed {
    logic                      req_type;
    logic signed [KEY_W-1:0]   lookup_key;
    logic signed [VALUE_W-1:0] write_value;
  } req_t;

  typedef struct packed {
    logic                      found;
    logic signed [VALUE_W-1:0] read_value;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic load_req;
    logic match;
    logic update;
    logic load_out;
  } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/lru_key_value_cache_core.sv =====
`default_nettype none
// Fully associative key-value cache with true LRU replacement over ENTRIES entries.
// Each request yields one result: found, and the value on a get hit (-1 on a get miss,
// 0 for any put). Steps per item: accept, key compare across all entries, rank and
// storage update with the value RAM read, then result load; compare result and RAM
// read are registered. The next item is taken once the previous result sits in the
// output register. No clearing pass after reset. capacity_in_use (cfg_data) is
// saturated to 1..ENTRIES; the user must write it only while idle, unenforced here.
module lru_key_value_cache_core #(
  parameter int ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  lkvc_pkg::req_t             in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output lkvc_pkg::rsp_t             out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0] cfg_data
);

  import lkvc_pkg::*;

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd)
  );

  lkvc_datapath #(
    .ENTRIES(ENTRIES)
  ) u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .in_data (in_data),
    .cfg_we  (cfg_valid & cfg_ready),
    .cfg_data(cfg_data),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/lkvc_ram.sv =====
`default_nettype none
module lkvc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/lkvc_ctrl.sv =====
`default_nettype none
module lkvc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output lkvc_pkg::cmd_t cmd
);

  import lkvc_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_MATCH;
        end
      end
      ST_MATCH:  state_nxt = ST_UPDATE;
      ST_UPDATE: state_nxt = ST_RESP;
      ST_RESP: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_req = in_valid;
      end
      ST_MATCH:  cmd.match  = 1'b1;
      ST_UPDATE: cmd.update = 1'b1;
      ST_RESP:   cmd.load_out = !out_valid_r || out_ready;
      default: begin
        in_ready = 1'b0;
      end
    endcase
    out_valid_nxt = cmd.load_out | (out_valid_r & ~out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// ===== rtl/lkvc_datapath.sv =====
`default_nettype none
module lkvc_datapath #(
  parameter int ENTRIES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lkvc_pkg::cmd_t                cmd,
  input  lkvc_pkg::req_t                in_data,
  input  logic                          cfg_we,
  input  logic [lkvc_pkg::CAP_W-1:0]    cfg_data,
  output lkvc_pkg::rsp_t                out_data
);

  import lkvc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;

  logic signed [KEY_W-1:0] key_r [ENTRIES];
  logic [IDX_W-1:0]        rank_r [ENTRIES];
  logic [IDX_W-1:0]        rank_nxt [ENTRIES];
  logic [ENTRIES-1:0]      valid;
  logic [ENTRIES-1:0]      hit_vec_r, hit_vec_nxt;
  logic [ENTRIES-1:0]      lru_vec_r, lru_vec_nxt;
  logic [OCC_W-1:0]        occ_r, occ_nxt, occ_last;
  logic [CAP_W-1:0]        cap_r;
  req_t                    req_r;
  logic                    found_r;
  rsp_t                    out_data_r, rsp_nxt;

  logic [CMP_W-1:0]        cap_ext, eff_cap;
  logic                    full, hit, put_miss, evict;
  logic [IDX_W-1:0]        hit_idx, hit_rank, lru_idx, slot;
  logic [VALUE_W-1:0]      ram_rdata;

  assign occ_last = occ_r - OCC_W'(1);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      valid[i]       = OCC_W'(i) < occ_r;
      hit_vec_nxt[i] = valid[i] && (key_r[i] == req_r.lookup_key);
      lru_vec_nxt[i] = valid[i] && (OCC_W'(rank_r[i]) == occ_last);
    end
  end

  always_comb begin
    hit_idx  = '0;
    hit_rank = '0;
    lru_idx  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec_r[i]) begin
        hit_idx  = hit_idx | IDX_W'(i);
        hit_rank = hit_rank | rank_r[i];
      end
      if (lru_vec_r[i]) begin
        lru_idx = lru_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    cap_ext = CMP_W'(cap_r);
    if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > CMP_W'(ENTRIES)) begin
      eff_cap = CMP_W'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign full     = CMP_W'(occ_r) >= eff_cap;
  assign hit      = |hit_vec_r;
  assign put_miss = (req_r.req_type == REQ_PUT) && !hit;
  assign evict    = put_miss && full;
  assign slot     = evict ? lru_idx : occ_r[IDX_W-1:0];
  assign occ_nxt  = occ_r + OCC_W'(put_miss && !evict);

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
      if (hit) begin
        if (hit_vec_r[i]) begin
          rank_nxt[i] = '0;
        end else if (valid[i] && (rank_r[i] < hit_rank)) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
      end else if (put_miss) begin
        if (IDX_W'(i) == slot) begin
          rank_nxt[i] = '0;
        end else if (valid[i]) begin
          rank_nxt[i] = rank_r[i] + IDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r     <= '0;
      cap_r     <= CAP_RESET;
      hit_vec_r <= '0;
      lru_vec_r <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (cmd.match) begin
        hit_vec_r <= hit_vec_nxt;
        lru_vec_r <= lru_vec_nxt;
      end
      if (cmd.update) begin
        occ_r <= occ_nxt;
        for (int i = 0; i < ENTRIES; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r <= in_data;
    end
    if (cmd.update) begin
      found_r <= hit;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd.update && put_miss && (slot == IDX_W'(i))) begin
        key_r[i] <= req_r.lookup_key;
      end
    end
    if (cmd.load_out) begin
      out_data_r <= rsp_nxt;
    end
  end

  lkvc_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(ENTRIES)
  ) u_value_ram (
    .clk  (clk),
    .we   (cmd.update && (req_r.req_type == REQ_PUT)),
    .waddr(hit ? hit_idx : slot),
    .wdata(req_r.write_value),
    .re   (cmd.update),
    .raddr(hit_idx),
    .rdata(ram_rdata)
  );

  always_comb begin
    rsp_nxt.found = found_r;
    if (req_r.req_type == REQ_PUT) begin
      rsp_nxt.read_value = '0;
    end else if (found_r) begin
      rsp_nxt.read_value = ram_rdata;
    end else begin
      rsp_nxt.read_value = MISS_VALUE;
    end
  end

  assign out_data = out_data_r;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(ENTRIES))
    else $error("occupancy beyond entry count");

  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (occ_r == $past(occ_r)) || (occ_r == $past(occ_r) + OCC_W'(1)))
    else $error("occupancy moved by more than one");

  a_hit_unique: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.match |=> $onehot0(hit_vec_r))
    else $error("key present in more than one entry");

  a_lru_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.match |=> ((occ_r == '0) ? (lru_vec_r == '0) : $onehot(lru_vec_r)))
    else $error("recency ranks are not a permutation");
`endif

endmodule
`default_nettype wire
